@@ sv/handle_id_allocator_defines.svh @@
// Assertion macros for the handle ID allocator.
// Taken in by the top level; depends on nothing.
`ifndef HANDLE_ID_ALLOCATOR_DEFINES_SVH
`define HANDLE_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("handle_id_allocator: assertion failed");

// Next-cycle implication, checked outside reset.
`define HIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("handle_id_allocator: assertion failed");

`endif

@@ sv/hia_pkg.sv @@
// Shared types, constants and helper functions of the handle ID allocator.
// No dependencies.
`default_nettype none

package hia_pkg;

    localparam int HANDLE_W = 10;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 2;

    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [CFG_W-1:0]    t_cfg_idx;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_REQUEST = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;
    localparam t_op OP_QUERY   = 2'd3;

    localparam t_cfg_idx CFG_MIN   = 2'd0;
    localparam t_cfg_idx CFG_MAX   = 2'd1;
    localparam t_cfg_idx CFG_START = 2'd2;

    localparam t_handle RST_MIN   = 10'd1;
    localparam t_handle RST_MAX   = 10'd1023;
    localparam t_handle RST_START = 10'd1;

    // Bits of a bitmap word whose handle lies within [first, last].
    function automatic t_word span_mask(t_handle base, t_handle first, t_handle last);
        t_word   m;
        t_handle h;
        m = '0;
        for (int i = 0; i < WORD_W; i++) begin
            h    = base | t_handle'(i);
            m[i] = (h >= first) && (h <= last);
        end
        return m;
    endfunction

    // Index of the lowest set bit (0 when none is set).
    function automatic logic [BIT_W-1:0] lowest_set(t_word v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ sv/hia_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire                                   i_re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/handle_id_allocator.sv @@
// Handle ID allocator: next-fit allocation of non-zero handles over a used bitmap.
// Depends on hia_pkg, hia_ram and handle_id_allocator_defines.svh.
`default_nettype none

// One word in, one word out. The used bitmap sits in a RAM of 32-bit words
// with registered read; each RAM word carries a flag flip-flop that reset
// clears, and a word whose flag is clear reads as all free, so there is no
// clearing pass after reset. Release, query and a request that is granted
// directly read one bitmap word, then evaluate and write back, then hand the
// result off to the output register. A release or query handle beyond the
// table is answered without a bitmap read. Allocate, and a request that
// falls back to allocate after reading its own word, sweeps the bitmap from
// the cursor word by word (RAM read then evaluate), then hands the result
// off to the output register. One word is worked on at a time; the next is
// taken once the result sits in the output register, while that result may
// still wait for the sink. Configuration writes (index 0 minimum handle, 1
// maximum handle, 2 start handle) reload the cursor from the start handle;
// the cursor is clamped into the current range when a sweep begins.
module handle_id_allocator #(
    parameter int HANDLE_COUNT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration write port
    input  wire                  i_cfg_we,
    input  wire  hia_pkg::t_cfg_idx i_cfg_addr,
    input  wire  hia_pkg::t_handle  i_cfg_wdata,
    // command stream
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire  [15:0]          i_s_axis_tdata,   // [9:0] handle_in, rest zero
    input  wire  [1:0]           i_s_axis_tuser,   // [1:0] op
    // result stream
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [9:0] handle_out, rest zero
    output logic                 o_m_axis_tuser    // [0] success
);

    import hia_pkg::*;

`include "handle_id_allocator_defines.svh"

    // Table geometry
    localparam int      MAP_DEPTH = (HANDLE_COUNT > 1024) ? 1024 : HANDLE_COUNT;
    localparam int      WORDS     = (MAP_DEPTH + WORD_W - 1) / WORD_W;
    localparam int      WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam t_handle TOP       = t_handle'(MAP_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration and cursor
    t_handle r_min, r_max, r_start, r_cursor, n_cursor;

    // Sequencer
    logic [1:0]    r_state, n_state;
    t_op           r_op, n_op;
    t_handle       r_h, n_h;
    t_handle       r_pos, n_pos;
    logic [WA-1:0] r_word, n_word;
    logic          r_scan, n_scan;     // sweeping for a free handle, else single check
    logic          r_phase, n_phase;   // second leg of the sweep, after the wrap
    t_handle       r_res_h, n_res_h;
    logic          r_res_ok, n_res_ok;
    logic [WORDS-1:0] r_valid;

    // Output register
    logic    r_out_valid;
    t_handle r_out_h;
    logic    r_out_ok;

    // Range, clamped cursor
    t_handle lo, hi, cur_pos;
    logic    empty;

    // Bitmap access
    t_word            ram_rdata, d, mask, free_bits;
    logic             ram_we;
    t_word            ram_wdata;
    logic [BIT_W-1:0] fbit, hbit_sel;
    logic             any_free, hbit;
    t_handle          base, grant;
    t_word            onehot_f, onehot_h;

    t_handle in_h;
    t_op     in_op;
    logic    in_acc;

    assign in_h   = i_s_axis_tdata[HANDLE_W-1:0];
    assign in_op  = i_s_axis_tuser;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign lo      = (r_min == '0) ? t_handle'(1) : r_min;
    always_comb begin
        hi = (r_max >= lo) ? r_max : TOP;
        if (hi > TOP) begin
            hi = TOP;
        end
    end
    assign empty   = lo > hi;
    assign cur_pos = (r_cursor < lo) ? lo : ((r_cursor > hi) ? hi : r_cursor);

    hia_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_word),
        .i_wdata(ram_wdata),
        .i_re   (r_state == S_RD),
        .i_raddr(r_word),
        .o_rdata(ram_rdata)
    );

    // Word not yet written since reset reads as all free
    assign d         = r_valid[r_word] ? ram_rdata : '0;
    assign base      = t_handle'({r_word, {BIT_W{1'b0}}});
    assign mask      = r_phase ? span_mask(base, lo, r_pos - t_handle'(1))
                               : span_mask(base, r_pos, hi);
    assign free_bits = ~d & mask;
    assign any_free  = |free_bits;
    assign fbit      = lowest_set(free_bits);
    assign grant     = t_handle'({r_word, fbit});
    assign hbit_sel  = r_h[BIT_W-1:0];
    assign hbit      = d[hbit_sel];
    assign onehot_f  = t_word'(1) << fbit;
    assign onehot_h  = t_word'(1) << hbit_sel;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_h       = r_h;
        n_pos     = r_pos;
        n_word    = r_word;
        n_scan    = r_scan;
        n_phase   = r_phase;
        n_res_h   = r_res_h;
        n_res_ok  = r_res_ok;
        n_cursor  = r_cursor;
        ram_we    = 1'b0;
        ram_wdata = d;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = in_op;
                    n_h     = in_h;
                    n_pos   = cur_pos;
                    n_phase = 1'b0;
                    n_res_h = in_h;
                    n_res_ok = 1'b0;
                    case (in_op) inside
                        OP_RELEASE, OP_QUERY: begin
                            // beyond the table: never held
                            if (in_h <= TOP) begin
                                n_scan  = 1'b0;
                                n_word  = in_h[BIT_W +: WA];
                                n_state = S_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            if (in_op == OP_REQUEST && in_h >= lo && in_h <= hi) begin
                                n_scan  = 1'b0;
                                n_word  = in_h[BIT_W +: WA];
                                n_state = S_RD;
                            end else if (empty) begin
                                n_res_h = '0;
                                n_state = S_DONE;
                            end else begin
                                n_scan  = 1'b1;
                                n_word  = cur_pos[BIT_W +: WA];
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_EV;
            end

            S_EV: begin
                if (!r_scan) begin
                    n_res_h = r_h;
                    case (r_op)
                        OP_REQUEST: begin
                            if (!hbit) begin
                                ram_we    = 1'b1;
                                ram_wdata = d | onehot_h;
                                n_res_ok  = 1'b1;
                                n_state   = S_DONE;
                            end else begin
                                // held: fall back to a sweep from the cursor
                                n_scan  = 1'b1;
                                n_word  = r_pos[BIT_W +: WA];
                                n_state = S_RD;
                            end
                        end
                        OP_RELEASE: begin
                            if (hbit) begin
                                ram_we    = 1'b1;
                                ram_wdata = d & ~onehot_h;
                            end
                            n_res_ok = hbit;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_res_ok = hbit;
                            n_state  = S_DONE;
                        end
                    endcase
                end else if (any_free) begin
                    ram_we    = 1'b1;
                    ram_wdata = d | onehot_f;
                    n_res_h   = grant;
                    n_res_ok  = 1'b1;
                    n_cursor  = (grant >= hi) ? lo : grant + t_handle'(1);
                    n_state   = S_DONE;
                end else if (!r_phase && r_word == hi[BIT_W +: WA]) begin
                    // top reached: wrap to the bottom of the range
                    n_phase = 1'b1;
                    n_word  = lo[BIT_W +: WA];
                    n_state = S_RD;
                end else if (r_phase && r_word == r_pos[BIT_W +: WA]) begin
                    // back at the start: range full
                    n_res_h  = '0;
                    n_res_ok = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_RD;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The user is to make Config writes only while idle; the block itself does
        // not enforce it. The stored start value is clamped when a sweep begins
        if (i_cfg_we) begin
            case (i_cfg_addr) inside
                CFG_START: n_cursor = i_cfg_wdata;
                CFG_MIN, CFG_MAX: n_cursor = r_start;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_min       <= RST_MIN;
            r_max       <= RST_MAX;
            r_start     <= RST_START;
            r_cursor    <= RST_START;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            if (ram_we) begin
                r_valid[r_word] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN:   r_min   <= i_cfg_wdata;
                    CFG_MAX:   r_max   <= i_cfg_wdata;
                    CFG_START: r_start <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_h      <= n_h;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_scan   <= n_scan;
        r_phase  <= n_phase;
        r_res_h  <= n_res_h;
        r_res_ok <= n_res_ok;
        if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_h  <= r_res_h;
            r_out_ok <= r_res_ok;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16 - HANDLE_W){1'b0}}, r_out_h};
    assign o_m_axis_tuser  = r_out_ok;

    // Bitmap is only written back in the evaluate step
    `HIA_ASSERT_NOW(a_we_in_eval, i_clk, i_rst_n, ram_we, r_state == S_EV)
    // An accepted word always leaves idle
    `HIA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    // A finished result with a free output slot is presented next cycle
    `HIA_ASSERT_NEXT(a_handoff, i_clk, i_rst_n,
        r_state == S_DONE && (!r_out_valid || i_m_axis_tready), o_m_axis_tvalid)
    // A swept grant lies within the range
    `HIA_ASSERT_NOW(a_grant_range, i_clk, i_rst_n,
        r_state == S_EV && r_scan && any_free, grant >= lo && grant <= hi)

endmodule

`default_nettype wire
